// ===== sv/circle_hex_edge_contact_core_assert.svh =====
// Assertion macros shared by the contact core.
`ifndef CIRCLE_HEX_EDGE_CONTACT_CORE_ASSERT_SVH
`define CIRCLE_HEX_EDGE_CONTACT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CHEX_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("contact core assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CHEX_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("contact core assertion failed");

`endif

// ===== sv/chex_pkg.sv =====
// Types and constants of the circle to hex edge contact pipeline.
package chex_pkg;

	localparam int CORNER_REGS = 6;
	localparam int DIV_STEPS   = 30;
	localparam int SQRT_STEPS  = 31;
	localparam int NORM_BITS   = 15;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_END   = 2'd1,
		MODE_FRAC  = 2'd2
	} proj_mode_t;

	typedef struct packed {
		logic               valid;
		logic [62:0]        rem;
		logic [62:0]        den;
		logic [29:0]        quo;
		proj_mode_t         mode;
		logic signed [30:0] ax;
		logic signed [30:0] ay;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic [30:0]        r;
	} div_cell_t;

	typedef struct packed {
		logic        valid;
		logic [60:0] x;
		logic [61:0] res;
		logic        hit;
		logic        sx;
		logic        sy;
		logic [29:0] mx;
		logic [29:0] my;
		logic [30:0] r;
	} sqrt_cell_t;

	typedef struct packed {
		logic        valid;
		logic [45:0] remx;
		logic [45:0] remy;
		logic [30:0] dlen;
		logic [14:0] qx;
		logic [14:0] qy;
		logic        hit;
		logic        sx;
		logic        sy;
		logic [30:0] r;
	} norm_cell_t;

endpackage

// ===== sv/chex_div_cell.sv =====
// One restoring division step of the projection parameter.
module chex_div_cell
	import chex_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  div_cell_t d_in,
	output div_cell_t d_out
);

	div_cell_t   cell_q;
	div_cell_t   nxt;
	logic [63:0] shifted;
	logic [63:0] diff;
	logic        take;

	always_comb begin
		shifted = {d_in.rem, 1'b0};
		diff    = shifted - {1'b0, d_in.den};
		take    = shifted >= {1'b0, d_in.den};
		nxt     = d_in;
		nxt.rem = take ? diff[62:0] : shifted[62:0];
		nxt.quo = {d_in.quo[28:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q.valid <= 1'b0;
		end else if (en) begin
			cell_q <= nxt;
		end
	end

	assign d_out = cell_q;

endmodule

// ===== sv/chex_sqrt_cell.sv =====
// One digit step of the integer square root of the squared distance.
module chex_sqrt_cell
	import chex_pkg::*;
#(
	parameter int STEP = 0
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  sqrt_cell_t d_in,
	output sqrt_cell_t d_out
);

	localparam logic [61:0] BIT = 62'(1) << (60 - 2 * STEP);

	sqrt_cell_t  cell_q;
	sqrt_cell_t  nxt;
	logic [61:0] trial;
	logic        take;

	always_comb begin
		trial = d_in.res + BIT;
		take  = {1'b0, d_in.x} >= trial;
		nxt   = d_in;
		if (take) begin
			nxt.x   = d_in.x - trial[60:0];
			nxt.res = (d_in.res >> 1) + BIT;
		end else begin
			nxt.res = d_in.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q.valid <= 1'b0;
		end else if (en) begin
			cell_q <= nxt;
		end
	end

	assign d_out = cell_q;

endmodule

// ===== sv/chex_norm_cell.sv =====
// One quotient bit of both normal components, divided by the distance.
module chex_norm_cell
	import chex_pkg::*;
#(
	parameter int SHIFT = 0
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  norm_cell_t d_in,
	output norm_cell_t d_out
);

	norm_cell_t  cell_q;
	norm_cell_t  nxt;
	logic [45:0] dsh;
	logic        take_x;
	logic        take_y;

	always_comb begin
		dsh    = 46'(d_in.dlen) << SHIFT;
		take_x = d_in.remx >= dsh;
		take_y = d_in.remy >= dsh;
		nxt    = d_in;
		if (take_x) begin
			nxt.remx      = d_in.remx - dsh;
			nxt.qx[SHIFT] = 1'b1;
		end
		if (take_y) begin
			nxt.remy      = d_in.remy - dsh;
			nxt.qy[SHIFT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q.valid <= 1'b0;
		end else if (en) begin
			cell_q <= nxt;
		end
	end

	assign d_out = cell_q;

endmodule

// ===== sv/circle_hex_edge_contact_core.sv =====
// Top level: contact of a circular body with one wall segment of a hex cell.
// Accepts one request per cycle while in_stall is low and returns one result
// per request, in order. The pipeline holds three rows of cells: 30 division
// cells that form the projection parameter t one bit each, 31 square-root
// cells that form the distance one digit each, and 15 cells that divide both
// normal components by the distance one quotient bit each. The six corner
// offsets sit in a small two-read-port register file written over the wr_en
// port; the user must write it only while the block is idle, which the block
// itself does not enforce. A result that cannot leave parks in a skid
// register; in_stall rises only while the skid register is occupied, and the
// whole pipeline holds in that cycle.
module circle_hex_edge_contact_core
	import chex_pkg::*;
#(
	parameter int CORNER_COUNT = 6
)
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [63:0]        wr_data,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] cell_x,
	input  logic signed [31:0] cell_y,
	input  logic signed [31:0] body_x,
	input  logic signed [31:0] body_y,
	input  logic [30:0]        radius,
	input  logic [2:0]         edge_req,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic [30:0]        depth,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y
);

	`include "circle_hex_edge_contact_core_assert.svh"

	localparam logic signed [33:0] REL_LIMIT = 34'sd1073741823;

	typedef struct packed {
		logic               hit;
		logic [30:0]        depth;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
	} result_t;

	logic en;

	// Corner register file: one write port, two registered read ports.
	logic [63:0]            corner_mem [CORNER_REGS];
	logic [CORNER_REGS-1:0] corner_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en && ({1'b0, wr_index} < 4'(CORNER_REGS))) begin
			corner_mem[wr_index] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_vld_q <= '0;
		end else if (wr_en && ({1'b0, wr_index} < 4'(CORNER_REGS))) begin
			corner_vld_q[wr_index] <= 1'b1;
		end
	end

	// Reduce the edge number and find the next corner; at most two folds.
	logic [3:0] e_fold;
	logic [2:0] e_idx;
	logic [3:0] f_inc;
	logic [2:0] f_idx;
	logic       e_ok;
	logic       f_ok;

	always_comb begin
		e_fold = {1'b0, edge_req};
		if (e_fold >= 4'(CORNER_COUNT)) begin
			e_fold = e_fold - 4'(CORNER_COUNT);
		end
		if (e_fold >= 4'(CORNER_COUNT)) begin
			e_fold = e_fold - 4'(CORNER_COUNT);
		end
		e_idx = e_fold[2:0];
		f_inc = e_fold + 4'd1;
		f_idx = (f_inc == 4'(CORNER_COUNT)) ? 3'd0 : f_inc[2:0];
		// corner slots past the register file read as the origin
		e_ok  = ({1'b0, e_idx} < 4'(CORNER_REGS)) && corner_vld_q[e_idx];
		f_ok  = ({1'b0, f_idx} < 4'(CORNER_REGS)) && corner_vld_q[f_idx];
	end

	// Stage 1: register the request and both corner reads.
	logic               v_s1;
	logic [63:0]        ce_s1;
	logic [63:0]        cf_s1;
	logic signed [31:0] cx_s1;
	logic signed [31:0] cy_s1;
	logic signed [31:0] bx_s1;
	logic signed [31:0] by_s1;
	logic [30:0]        r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ce_s1 <= e_ok ? corner_mem[e_idx] : 64'd0;
			cf_s1 <= f_ok ? corner_mem[f_idx] : 64'd0;
			cx_s1 <= cell_x;
			cy_s1 <= cell_y;
			bx_s1 <= body_x;
			by_s1 <= body_y;
			r_s1  <= radius;
		end
	end

	// Stage 2: endpoints relative to the body, saturated.
	function automatic logic signed [30:0] rel_sat(input logic signed [31:0] c,
		input logic signed [31:0] k, input logic signed [31:0] b);
		logic signed [33:0] s;
		s = 34'(c) + 34'(k) - 34'(b);
		if (s > REL_LIMIT) begin
			s = REL_LIMIT;
		end else if (s < -REL_LIMIT) begin
			s = -REL_LIMIT;
		end
		return s[30:0];
	endfunction

	logic               v_s2;
	logic signed [30:0] ax_s2;
	logic signed [30:0] ay_s2;
	logic signed [30:0] qx_s2;
	logic signed [30:0] qy_s2;
	logic [30:0]        r_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2 <= rel_sat(cx_s1, signed'(ce_s1[63:32]), bx_s1);
			ay_s2 <= rel_sat(cy_s1, signed'(ce_s1[31:0]), by_s1);
			qx_s2 <= rel_sat(cx_s1, signed'(cf_s1[63:32]), bx_s1);
			qy_s2 <= rel_sat(cy_s1, signed'(cf_s1[31:0]), by_s1);
			r_s2  <= r_s1;
		end
	end

	// Stage 3: segment direction.
	logic               v_s3;
	logic signed [30:0] ax_s3;
	logic signed [30:0] ay_s3;
	logic signed [31:0] vx_s3;
	logic signed [31:0] vy_s3;
	logic [30:0]        r_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
			vx_s3 <= 32'(qx_s2) - 32'(ax_s2);
			vy_s3 <= 32'(qy_s2) - 32'(ay_s2);
			r_s3  <= r_s2;
		end
	end

	// Stage 4: the four products of the projection.
	logic               v_s4;
	logic signed [62:0] pax_s4;
	logic signed [62:0] pay_s4;
	logic signed [62:0] pvx_s4;
	logic signed [62:0] pvy_s4;
	logic signed [30:0] ax_s4;
	logic signed [30:0] ay_s4;
	logic signed [31:0] vx_s4;
	logic signed [31:0] vy_s4;
	logic [30:0]        r_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pax_s4 <= ax_s3 * vx_s3;
			pay_s4 <= ay_s3 * vy_s3;
			pvx_s4 <= vx_s3 * vx_s3;
			pvy_s4 <= vy_s3 * vy_s3;
			ax_s4  <= ax_s3;
			ay_s4  <= ay_s3;
			vx_s4  <= vx_s3;
			vy_s4  <= vy_s3;
			r_s4   <= r_s3;
		end
	end

	// Stage 5: numerator, denominator and clamp mode; feeds the division row.
	logic signed [63:0] num;
	logic [62:0]        den;
	div_cell_t          div_in;
	div_cell_t          div_chain [DIV_STEPS+1];

	always_comb begin
		num          = -(64'(pax_s4) + 64'(pay_s4));
		den          = {1'b0, pvx_s4[61:0]} + {1'b0, pvy_s4[61:0]};
		div_in.valid = v_s4;
		div_in.rem   = num[62:0];
		div_in.den   = den;
		div_in.quo   = '0;
		div_in.ax    = ax_s4;
		div_in.ay    = ay_s4;
		div_in.vx    = vx_s4;
		div_in.vy    = vy_s4;
		div_in.r     = r_s4;
		if ((den == 63'd0) || (num <= 64'sd0)) begin
			div_in.mode = MODE_START;
		end else if (num >= signed'({1'b0, den})) begin
			div_in.mode = MODE_END;
		end else begin
			div_in.mode = MODE_FRAC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_chain[0].valid <= 1'b0;
		end else if (en) begin
			div_chain[0] <= div_in;
		end
	end

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		chex_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d_in   (div_chain[i]),
			.d_out  (div_chain[i+1])
		);
	end

	// Stage 6: pick t (start, end or quotient) and scale |V| by it.
	div_cell_t   dv;
	logic [30:0] t_sel;
	logic [30:0] mvx;
	logic [30:0] mvy;

	always_comb begin
		dv = div_chain[DIV_STEPS];
		case (dv.mode)
			MODE_START: t_sel = 31'd0;
			MODE_END:   t_sel = 31'h4000_0000;
			MODE_FRAC:  t_sel = {1'b0, dv.quo};
			default:    t_sel = 31'd0;
		endcase
		mvx = dv.vx[31] ? 31'(-dv.vx) : dv.vx[30:0];
		mvy = dv.vy[31] ? 31'(-dv.vy) : dv.vy[30:0];
	end

	logic               v_s6;
	logic [61:0]        sxp_s6;
	logic [61:0]        syp_s6;
	logic               nvx_s6;
	logic               nvy_s6;
	logic signed [30:0] ax_s6;
	logic signed [30:0] ay_s6;
	logic [30:0]        r_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= dv.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sxp_s6 <= mvx * t_sel;
			syp_s6 <= mvy * t_sel;
			nvx_s6 <= dv.vx[31];
			nvy_s6 <= dv.vy[31];
			ax_s6  <= dv.ax;
			ay_s6  <= dv.ay;
			r_s6   <= dv.r;
		end
	end

	// Stage 7: closest point, rounded half up in magnitude.
	logic [61:0]        rx;
	logic [61:0]        ry;
	logic signed [32:0] px_full;
	logic signed [32:0] py_full;

	always_comb begin
		rx      = sxp_s6 + 62'h2000_0000;
		ry      = syp_s6 + 62'h2000_0000;
		px_full = nvx_s6 ? 33'(ax_s6) - 33'(rx[61:30]) : 33'(ax_s6) + 33'(rx[61:30]);
		py_full = nvy_s6 ? 33'(ay_s6) - 33'(ry[61:30]) : 33'(ay_s6) + 33'(ry[61:30]);
	end

	logic               v_s7;
	logic signed [30:0] px_s7;
	logic signed [30:0] py_s7;
	logic [30:0]        r_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s7 <= px_full[30:0];
			py_s7 <= py_full[30:0];
			r_s7  <= r_s6;
		end
	end

	// Stage 8: squares of the point and of the radius.
	logic [29:0] mpx;
	logic [29:0] mpy;

	always_comb begin
		mpx = px_s7[30] ? 30'(-px_s7) : px_s7[29:0];
		mpy = py_s7[30] ? 30'(-py_s7) : py_s7[29:0];
	end

	logic        v_s8;
	logic [59:0] sqx_s8;
	logic [59:0] sqy_s8;
	logic [61:0] r2_s8;
	logic [29:0] mx_s8;
	logic [29:0] my_s8;
	logic        sx_s8;
	logic        sy_s8;
	logic [30:0] r_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s8 <= mpx * mpx;
			sqy_s8 <= mpy * mpy;
			r2_s8  <= r_s7 * r_s7;
			mx_s8  <= mpx;
			my_s8  <= mpy;
			sx_s8  <= px_s7[30];
			sy_s8  <= py_s7[30];
			r_s8   <= r_s7;
		end
	end

	// Stage 9: squared distance and hit test; feeds the square-root row.
	sqrt_cell_t  sq_in;
	sqrt_cell_t  sqrt_chain [SQRT_STEPS+1];
	logic [60:0] d2;

	always_comb begin
		d2          = 61'(sqx_s8) + 61'(sqy_s8);
		sq_in.valid = v_s8;
		sq_in.x     = d2;
		sq_in.res   = '0;
		sq_in.hit   = {1'b0, d2} <= r2_s8;
		sq_in.sx    = sx_s8;
		sq_in.sy    = sy_s8;
		sq_in.mx    = mx_s8;
		sq_in.my    = my_s8;
		sq_in.r     = r_s8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqrt_chain[0].valid <= 1'b0;
		end else if (en) begin
			sqrt_chain[0] <= sq_in;
		end
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		chex_sqrt_cell #(
			.STEP (k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d_in   (sqrt_chain[k]),
			.d_out  (sqrt_chain[k+1])
		);
	end

	// Stage 10: normal dividends |P| * 2^14 + dist/2; feeds the normal row.
	sqrt_cell_t  sr;
	norm_cell_t  nm_in;
	norm_cell_t  norm_chain [NORM_BITS+1];
	logic [30:0] dlen;

	always_comb begin
		sr          = sqrt_chain[SQRT_STEPS];
		dlen        = sr.res[30:0];
		nm_in.valid = sr.valid;
		nm_in.remx  = {2'b00, sr.mx, 14'd0} + 46'(dlen[30:1]);
		nm_in.remy  = {2'b00, sr.my, 14'd0} + 46'(dlen[30:1]);
		nm_in.dlen  = dlen;
		nm_in.qx    = '0;
		nm_in.qy    = '0;
		nm_in.hit   = sr.hit;
		nm_in.sx    = sr.sx;
		nm_in.sy    = sr.sy;
		nm_in.r     = sr.r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_chain[0].valid <= 1'b0;
		end else if (en) begin
			norm_chain[0] <= nm_in;
		end
	end

	// quotient bits go from the top bit down
	for (genvar j = 0; j < NORM_BITS; j++) begin : g_norm
		chex_norm_cell #(
			.SHIFT (NORM_BITS - 1 - j)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d_in   (norm_chain[j]),
			.d_out  (norm_chain[j+1])
		);
	end

	// Result formatting: zero everything on a miss, zero normal at zero distance.
	norm_cell_t nl;
	result_t    res;

	always_comb begin
		nl        = norm_chain[NORM_BITS];
		res.hit   = nl.hit;
		res.depth = nl.hit ? (nl.r - nl.dlen) : 31'd0;
		res.nx    = '0;
		res.ny    = '0;
		if (nl.hit && (nl.dlen != 31'd0)) begin
			res.nx = nl.sx ? -signed'(16'(nl.qx)) : signed'(16'(nl.qx));
			res.ny = nl.sy ? -signed'(16'(nl.qy)) : signed'(16'(nl.qy));
		end
	end

	// Output register and skid register; hold the pipeline while skid is full.
	logic    out_valid_q;
	result_t out_q;
	logic    skid_valid_q;
	result_t skid_q;
	logic    out_free;

	assign en       = !skid_valid_q;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= nl.valid;
			end
		end else if (en && nl.valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (en && nl.valid) begin
			skid_q <= res;
		end
	end

	assign in_stall  = skid_valid_q;
	assign out_valid = out_valid_q;
	assign hit       = out_q.hit;
	assign depth     = out_q.depth;
	assign normal_x  = out_q.nx;
	assign normal_y  = out_q.ny;

	`CHEX_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q)
	`CHEX_ASSERT_NEXT(a_skid_holds, skid_valid_q && out_stall, skid_valid_q)
	`CHEX_ASSERT_NOW(a_miss_is_zero, out_valid_q && !out_q.hit,
		(out_q.depth == 31'd0) && (out_q.nx == 16'sd0) && (out_q.ny == 16'sd0))
	`CHEX_ASSERT_NOW(a_normal_range, out_valid_q,
		(out_q.nx <= 16'sd16384) && (out_q.nx >= -16'sd16384) &&
		(out_q.ny <= 16'sd16384) && (out_q.ny >= -16'sd16384))

endmodule

// ===== tb/sv/tb_circle_hex_edge_contact_core.sv =====
// Self-checking testbench for the circle to hex edge contact core.
module tb_circle_hex_edge_contact_core;
	import chex_pkg::*;

	localparam int CORNERS     = 6;
	localparam int SETTLE_CYC  = 120;   // settle time, longer than the pipeline depth
	localparam longint REL_MAX = 64'sd1073741823;

	typedef struct {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic [30:0]        rad;
		logic [2:0]         edg;
	} query_t;

	typedef struct {
		logic               hit;
		logic [30:0]        depth;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
	} contact_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               wr_en = 1'b0;
	logic [2:0]         wr_index = '0;
	logic [63:0]        wr_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] cell_x = '0;
	logic signed [31:0] cell_y = '0;
	logic signed [31:0] body_x = '0;
	logic signed [31:0] body_y = '0;
	logic [30:0]        radius = '0;
	logic [2:0]         edge_req = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               hit;
	logic [30:0]        depth;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;

	circle_hex_edge_contact_core #(.CORNER_COUNT(CORNERS)) uut (.*);

	// shadow of the corner register file
	logic [63:0] corner_shadow [CORNERS];

	query_t   pending_q [$];
	contact_t contact_q [$];
	int       accepted_cnt = 0;
	int       issued_cnt = 0;
	int       checked_cnt = 0;
	int       hit_cnt = 0;
	int       fail_cnt = 0;
	int       burst_left = 4;
	int       gap_left = 0;
	int       stall_left = 0;
	int       stall_mode = 0;
	int       mode_left = 100;

	initial begin
		forever #2 clk = ~clk;
	end

	// keep relative coordinates inside the 31-bit signed window
	function automatic longint clamp_rel(longint v);
		if (v > REL_MAX) return REL_MAX;
		if (v < -REL_MAX) return -REL_MAX;
		return v;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned x);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > x) bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (x >= res + bit_v) begin
				x = x - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// rounded |v| * t / 2^30 with the sign of v
	function automatic longint step_along(longint v, longint unsigned t);
		longint unsigned m;
		longint s;
		m = (v < 0) ? longint'(-v) : longint'(v);
		s = longint'((m * t + (64'd1 << 29)) >> 30);
		return (v < 0) ? -s : s;
	endfunction

	function automatic logic signed [15:0] unit_comp(longint p, longint unsigned dlen);
		longint unsigned m, q;
		m = (p < 0) ? longint'(-p) : longint'(p);
		q = (m * 64'd16384 + dlen / 2) / dlen;
		if (q > 64'd16384) q = 64'd16384;
		return (p < 0) ? -16'(q) : 16'(q);
	endfunction

	function automatic contact_t edge_contact(query_t q);
		contact_t res;
		int e, f;
		logic signed [31:0] exo, eyo, fxo, fyo;
		longint ax, ay, qx, qy, vx, vy, num, px, py;
		longint unsigned den, rem, t, d2, r, dlen;
		e = int'(q.edg) % CORNERS;
		f = (e + 1) % CORNERS;
		exo = corner_shadow[e][63:32];
		eyo = corner_shadow[e][31:0];
		fxo = corner_shadow[f][63:32];
		fyo = corner_shadow[f][31:0];
		ax = clamp_rel(longint'(q.cx) + longint'(exo) - longint'(q.bx));
		ay = clamp_rel(longint'(q.cy) + longint'(eyo) - longint'(q.by));
		qx = clamp_rel(longint'(q.cx) + longint'(fxo) - longint'(q.bx));
		qy = clamp_rel(longint'(q.cy) + longint'(fyo) - longint'(q.by));
		vx = qx - ax;
		vy = qy - ay;
		num = -(ax * vx + ay * vy);
		den = longint'(vx * vx);
		den = den + longint'(vy * vy);
		if (den == 0 || num <= 0) begin
			px = ax;
			py = ay;
		end else if (longint'(num) >= den) begin
			px = qx;
			py = qy;
		end else begin
			// restoring division for the Q0.30 parameter
			rem = num;
			t = 0;
			for (int i = 0; i < 30; i++) begin
				rem = rem << 1;
				t = t << 1;
				if (rem >= den) begin
					rem = rem - den;
					t = t | 64'd1;
				end
			end
			px = ax + step_along(vx, t);
			py = ay + step_along(vy, t);
		end
		d2 = longint'(px * px);
		d2 = d2 + longint'(py * py);
		r = {33'd0, q.rad};
		res = '{hit: 1'b0, depth: '0, nx: '0, ny: '0};
		if (d2 > r * r) return res;
		dlen = root_floor(d2);
		res.hit = 1'b1;
		res.depth = 31'(r - dlen);
		if (dlen != 0) begin
			res.nx = unit_comp(px, dlen);
			res.ny = unit_comp(py, dlen);
		end
		return res;
	endfunction

	// Driver: present queued requests in bursts separated by random gaps.
	always @(negedge clk) begin
		query_t cur;
		if (arst_n && !(in_valid && accepted_cnt < issued_cnt)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_q.size() > 0) begin
				cur = pending_q.pop_front();
				cell_x <= cur.cx;
				cell_y <= cur.cy;
				body_x <= cur.bx;
				body_y <= cur.by;
				radius <= cur.rad;
				edge_req <= cur.edg;
				in_valid <= 1'b1;
				issued_cnt++;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					// some bursts run straight into the next
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure: switch between free flow, scattered stalls
	// and long stall bursts.
	always @(negedge clk) begin
		if (arst_n) begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(40, 250);
			end else begin
				mode_left--;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (stall_mode == 1) begin
				out_stall <= ($urandom_range(0, 2) == 0);
			end else if (stall_mode == 2 && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 20);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Monitor: predict on request acceptance, check on result acceptance.
	always @(posedge clk) begin
		query_t   q;
		contact_t exp_c;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				q = '{cx: cell_x, cy: cell_y, bx: body_x, by: body_y,
					rad: radius, edg: edge_req};
				contact_q.push_back(edge_contact(q));
				accepted_cnt++;
			end
			if (out_valid && !out_stall) begin
				if (contact_q.size() == 0) begin
					$error("result with no request outstanding");
					fail_cnt++;
				end else begin
					exp_c = contact_q.pop_front();
					checked_cnt++;
					if (exp_c.hit) hit_cnt++;
					if (hit !== exp_c.hit) begin
						$error("hit: expected %0d, got %0d", exp_c.hit, hit);
						fail_cnt++;
					end
					if (depth !== exp_c.depth) begin
						$error("depth: expected %0d, got %0d", exp_c.depth, depth);
						fail_cnt++;
					end
					if (normal_x !== exp_c.nx) begin
						$error("normal_x: expected %0d, got %0d", exp_c.nx, normal_x);
						fail_cnt++;
					end
					if (normal_y !== exp_c.ny) begin
						$error("normal_y: expected %0d, got %0d", exp_c.ny, normal_y);
						fail_cnt++;
					end
				end
			end
		end
	end

	// hold off until every request has left and its result has come back
	task automatic drain();
		wait (pending_q.size() == 0 && accepted_cnt == issued_cnt && contact_q.size() == 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_corner(int idx, logic [63:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx[2:0];
		wr_data <= val;
		corner_shadow[idx] = val;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// regular hex of the given corner distance (Q16.16), with optional jitter
	task automatic load_hex(int unsigned size, int unsigned jitter);
		int signed hx, hy;
		for (int i = 0; i < CORNERS; i++) begin
			hx = int'($cos(3.14159265 * i / 3.0) * size) + $urandom_range(0, jitter);
			hy = int'($sin(3.14159265 * i / 3.0) * size) - $urandom_range(0, jitter);
			write_corner(i, {hx, hy});
		end
	endtask

	// Random request: mostly near the cell so contacts happen, some pure noise.
	task automatic queue_random(int count, int unsigned span);
		query_t q;
		for (int n = 0; n < count; n++) begin
			q.cx = $urandom();
			q.cy = $urandom();
			q.edg = 3'($urandom_range(0, 7));
			if ($urandom_range(0, 9) == 0) begin
				q.bx = $urandom();
				q.by = $urandom();
				q.rad = 31'($urandom());
			end else begin
				q.bx = q.cx + int'($urandom_range(0, 4 * span)) - int'(2 * span);
				q.by = q.cy + int'($urandom_range(0, 4 * span)) - int'(2 * span);
				q.rad = 31'($urandom_range(0, 3 * span));
			end
			pending_q.push_back(q);
		end
	endtask

	task automatic queue_one(int cx, int cy, int bx, int by, int unsigned rad, int edg);
		query_t q;
		q = '{cx: cx, cy: cy, bx: bx, by: by, rad: 31'(rad), edg: 3'(edg)};
		pending_q.push_back(q);
	endtask

	initial begin
		for (int i = 0; i < CORNERS; i++) corner_shadow[i] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// All corners at reset: every segment collapses onto the cell centre.
		queue_one(0, 0, 0, 0, 0, 0);
		queue_one(32'h10000, 0, 0, 0, 32'h20000, 1);
		queue_random(30, 32'h40000);
		drain();

		// Regular hex, corner distance three units: directed cases first.
		load_hex(32'h30000, 0);
		queue_one(0, 0, 0, 0, 32'h10000, 0);                      // body at cell centre
		queue_one(0, 0, 32'h30000, 0, 32'h8000, 0);               // zero distance at a corner
		queue_one(0, 0, 32'h30000, 0, 0, 5);                      // zero radius, touching
		queue_one(0, 0, 32'h40000, 0, 32'h20000, 0);              // beyond start, clamps to A
		queue_one(0, 0, 32'h28000, 32'h30000, 32'h18000, 0);      // interior projection
		queue_one(0, 0, -32'h40000, 0, 32'h20000, 2);             // beyond end, clamps to B
		queue_one(0, 0, 32'h100000, 0, 32'h8000, 3);              // clean miss
		queue_one(0, 0, 0, 32'h30000, 32'h10000, 6);              // edge index wraps
		queue_one(0, 0, 0, -32'h30000, 32'h10000, 7);
		queue_one(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 4);
		queue_one(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff, 1);
		queue_one(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 31'h7fffffff, 2);
		queue_one(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, 3);
		queue_one(0, 0, 32'h7fffffff, 32'h80000000, 31'h7fffffff, 5);
		queue_random(110, 32'h30000);
		drain();

		// Corners at the limits of the offset range: saturating endpoints.
		write_corner(0, 64'h7fffffff_80000000);
		write_corner(1, 64'h80000000_7fffffff);
		write_corner(2, 64'hffffffff_ffffffff);
		write_corner(3, 64'h00000000_00000000);
		write_corner(4, 64'h7fffffff_7fffffff);
		write_corner(5, 64'h80000000_80000000);
		queue_random(60, 32'h1000000);
		drain();

		// Tiny jittered hex: sub-unit distances and coarse normals.
		load_hex(32'h100, 32'h20);
		queue_random(80, 32'h100);
		drain();

		// Degenerate edges: repeated corners give zero-length segments.
		write_corner(0, 64'h00010000_00020000);
		write_corner(1, 64'h00010000_00020000);
		write_corner(2, 64'hfffe0000_00010000);
		write_corner(3, 64'hfffe0000_00010000);
		write_corner(4, 64'h00000000_fffd0000);
		write_corner(5, 64'h00030000_00000000);
		queue_random(60, 32'h40000);
		drain();

		// Large jittered hex with random content.
		load_hex(32'h2000000, 32'h100000);
		queue_random(90, 32'h2000000);
		drain();

		$display("Checked %0d contact results (%0d hits) over six corner layouts,",
			checked_cnt, hit_cnt);
		$display("including saturated, degenerate and tiny hex geometry.");
		if (fail_cnt == 0 && contact_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/chex_pkg.sv
sv/chex_div_cell.sv
sv/chex_sqrt_cell.sv
sv/chex_norm_cell.sv
sv/circle_hex_edge_contact_core.sv
tb/sv/tb_circle_hex_edge_contact_core.sv
